// ===== rtl/gsv_pkg.sv =====
// Shared types, constants and neighbour tables for the grid sector view unit.
package gsv_pkg;

  localparam int unsigned SECTOR_PIXEL_WIDTH  = 128;
  localparam int unsigned SECTOR_PIXEL_HEIGHT = 128;
  localparam int unsigned GRID_WIDTH          = 64;
  localparam int unsigned GRID_HEIGHT         = 64;
  localparam int unsigned CELL_LIMIT          = 64;

  localparam int unsigned WORLD_W  = 15;
  localparam int unsigned CELL_W   = 6;
  localparam int unsigned NSEC_W   = 8;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned RECIP_W  = 16;
  localparam int unsigned NB_N     = 9;
  localparam int unsigned NB_IDX_W = 4;
  localparam int unsigned COORD_W  = 10;

  localparam logic [NB_IDX_W-1:0] NB_CENTRE = NB_IDX_W'(4);

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_NEIGH  = 2'd1,
    KIND_LEAVE  = 2'd2,
    KIND_ENTER  = 2'd3
  } kind_e;

  typedef struct packed {
    logic               mode;
    logic [CELL_W-1:0]  sector_x;
    logic [CELL_W-1:0]  sector_y;
    logic               include_centre;
    logic [WORLD_W-1:0] world_x;
    logic [WORLD_W-1:0] world_y;
  } req_t;

  typedef struct packed {
    logic               mode;
    logic [CELL_W-1:0]  sector_x;
    logic [CELL_W-1:0]  sector_y;
    logic               include_centre;
    logic [WORLD_W-1:0] quot_x;
    logic [WORLD_W-1:0] quot_y;
  } dec_t;

  typedef struct packed {
    kind_e              kind;
    logic [CELL_W-1:0]  cell_x;
    logic [CELL_W-1:0]  cell_y;
    logic [NSEC_W-1:0]  new_sector_x;
    logic [NSEC_W-1:0]  new_sector_y;
    logic               out_of_range;
    logic               moved;
    logic [CNT_W-1:0]   listed_count;
    logic               last;
  } res_t;

  // Row-major 3x3 offsets: rows top to bottom, columns left to right.
  localparam logic signed [1:0] NB_DX [NB_N] = '{
    -2'sd1, 2'sd0, 2'sd1,
    -2'sd1, 2'sd0, 2'sd1,
    -2'sd1, 2'sd0, 2'sd1
  };
  localparam logic signed [1:0] NB_DY [NB_N] = '{
    -2'sd1, -2'sd1, -2'sd1,
     2'sd0,  2'sd0,  2'sd0,
     2'sd1,  2'sd1,  2'sd1
  };

  function automatic logic [CNT_W-1:0] popcount9(input logic [NB_N-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NB_N; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/gsv_front.sv =====
// Input register and reciprocal-multiply stage turning world position into sector.
module gsv_front import gsv_pkg::*; #(
  parameter int unsigned SectorPixelWidth  = SECTOR_PIXEL_WIDTH,
  parameter int unsigned SectorPixelHeight = SECTOR_PIXEL_HEIGHT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic dec_valid_o,
  input  logic dec_ready_i,
  output dec_t dec_o
);

  localparam int unsigned LogW   = $clog2(SectorPixelWidth);
  localparam int unsigned LogH   = $clog2(SectorPixelHeight);
  // floor(2^(N+l)/d)+1 gives an exact quotient for every N-bit dividend
  localparam int unsigned RecipX = ((1 << (WORLD_W + LogW)) / SectorPixelWidth) + 1;
  localparam int unsigned RecipY = ((1 << (WORLD_W + LogH)) / SectorPixelHeight) + 1;
  localparam logic [RECIP_W-1:0] RecipXv = RECIP_W'(RecipX);
  localparam logic [RECIP_W-1:0] RecipYv = RECIP_W'(RecipY);
  localparam int unsigned ProdW = WORLD_W + RECIP_W;

  logic s1_v_q, s2_v_q;
  logic s1_rdy, s2_rdy;
  req_t req_q;
  dec_t dec_q, dec_d;
  logic [ProdW-1:0] prod_x, prod_y;

  assign s2_rdy     = !s2_v_q || dec_ready_i;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  always_comb begin
    prod_x = ProdW'(req_q.world_x) * ProdW'(RecipXv);
    prod_y = ProdW'(req_q.world_y) * ProdW'(RecipYv);
    dec_d.mode           = req_q.mode;
    dec_d.sector_x       = req_q.sector_x;
    dec_d.sector_y       = req_q.sector_y;
    dec_d.include_centre = req_q.include_centre;
    dec_d.quot_x         = WORLD_W'(prod_x >> (WORLD_W + LogW));
    dec_d.quot_y         = WORLD_W'(prod_y >> (WORLD_W + LogH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) req_q <= in_req_i;
    if (s2_rdy && s1_v_q)     dec_q <= dec_d;
  end

  assign dec_valid_o = s2_v_q;
  assign dec_o       = dec_q;

endmodule

// ===== rtl/gsv_emit.sv =====
// View planner: builds leave/enter/neighbour masks and steps them out one beat a cycle while the output is free.
module gsv_emit import gsv_pkg::*; #(
  parameter int unsigned GridWidth  = GRID_WIDTH,
  parameter int unsigned GridHeight = GRID_HEIGHT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic dec_valid_i,
  output logic dec_ready_o,
  input  dec_t dec_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  localparam int unsigned LimX = (GridWidth  < CELL_LIMIT) ? GridWidth  : CELL_LIMIT;
  localparam int unsigned LimY = (GridHeight < CELL_LIMIT) ? GridHeight : CELL_LIMIT;
  localparam int unsigned PendW = 2 * NB_N;

  // planner state
  logic                busy_q;
  logic [PendW-1:0]    pend_q;
  kind_e               list_kind_q;
  logic [CELL_W-1:0]   oc_x_q, oc_y_q;
  logic [NSEC_W-1:0]   nc_x_q, nc_y_q;
  logic [NSEC_W-1:0]   st_nsx_q, st_nsy_q;
  logic                st_oor_q, st_moved_q;
  logic [CNT_W-1:0]    st_cnt_q;
  logic                out_v_q;
  res_t                out_q;

  logic out_free, step, fin, load;

  // decode of the incoming item
  logic                oor, same, moved;
  logic [NSEC_W-1:0]   ncx, ncy, sat_x, sat_y;
  logic signed [COORD_W-1:0] ox, oy, nx, ny, dox, doy, dnx, dny;
  logic [NB_N-1:0]     ov, nv, near_new, near_old, list0, leave, enter;
  logic [PendW-1:0]    pend_load;
  logic [CNT_W-1:0]    cnt_load;

  // beat selection
  logic                sel_new;
  logic [NB_IDX_W-1:0] idx_lo, idx_hi, nb;
  logic [NSEC_W-1:0]   base_x, base_y;
  res_t                res_d;

  assign out_free    = !out_v_q || res_ready_i;
  assign step        = busy_q && out_free;
  assign fin         = step && (pend_q == '0);
  assign dec_ready_o = !busy_q || fin;
  assign load        = dec_valid_i && dec_ready_o;

  always_comb begin
    oor   = (dec_i.quot_x >= WORLD_W'(GridWidth)) || (dec_i.quot_y >= WORLD_W'(GridHeight));
    same  = (dec_i.quot_x == WORLD_W'(dec_i.sector_x)) &&
            (dec_i.quot_y == WORLD_W'(dec_i.sector_y));
    moved = dec_i.mode && !oor && !same;
    ncx   = dec_i.quot_x[NSEC_W-1:0];
    ncy   = dec_i.quot_y[NSEC_W-1:0];
    sat_x = (|dec_i.quot_x[WORLD_W-1:NSEC_W]) ? '1 : dec_i.quot_x[NSEC_W-1:0];
    sat_y = (|dec_i.quot_y[WORLD_W-1:NSEC_W]) ? '1 : dec_i.quot_y[NSEC_W-1:0];

    for (int i = 0; i < NB_N; i++) begin
      ox  = signed'(COORD_W'(dec_i.sector_x)) + COORD_W'(NB_DX[i]);
      oy  = signed'(COORD_W'(dec_i.sector_y)) + COORD_W'(NB_DY[i]);
      nx  = signed'(COORD_W'(ncx)) + COORD_W'(NB_DX[i]);
      ny  = signed'(COORD_W'(ncy)) + COORD_W'(NB_DY[i]);
      dox = ox - signed'(COORD_W'(ncx));
      doy = oy - signed'(COORD_W'(ncy));
      dnx = nx - signed'(COORD_W'(dec_i.sector_x));
      dny = ny - signed'(COORD_W'(dec_i.sector_y));
      ov[i] = (ox >= 0) && (ox < signed'(COORD_W'(LimX))) &&
              (oy >= 0) && (oy < signed'(COORD_W'(LimY)));
      nv[i] = (nx >= 0) && (nx < signed'(COORD_W'(LimX))) &&
              (ny >= 0) && (ny < signed'(COORD_W'(LimY)));
      near_new[i] = (dox >= -1) && (dox <= 1) && (doy >= -1) && (doy <= 1);
      near_old[i] = (dnx >= -1) && (dnx <= 1) && (dny >= -1) && (dny <= 1);
      list0[i] = ov[i] && (dec_i.include_centre || (NB_IDX_W'(i) != NB_CENTRE));
      leave[i] = ov[i] && !near_new[i];
      enter[i] = nv[i] && !near_old[i];
    end

    if (!dec_i.mode) begin
      pend_load = {{NB_N{1'b0}}, list0};
      cnt_load  = popcount9(list0);
    end else if (moved) begin
      pend_load = {enter, leave};
      cnt_load  = popcount9(enter);
    end else begin
      pend_load = '0;
      cnt_load  = '0;
    end
  end

  // lowest pending bit: old-centre list first, then entering list
  always_comb begin
    idx_lo = '0;
    idx_hi = '0;
    for (int i = NB_N - 1; i >= 0; i--) begin
      if (pend_q[i])        idx_lo = NB_IDX_W'(i);
      if (pend_q[NB_N + i]) idx_hi = NB_IDX_W'(i);
    end
    sel_new = ~|pend_q[NB_N-1:0];
    nb      = sel_new ? idx_hi : idx_lo;
    base_x  = sel_new ? nc_x_q : NSEC_W'(oc_x_q);
    base_y  = sel_new ? nc_y_q : NSEC_W'(oc_y_q);

    res_d = '0;
    if (pend_q == '0) begin
      res_d.kind         = KIND_STATUS;
      res_d.new_sector_x = st_nsx_q;
      res_d.new_sector_y = st_nsy_q;
      res_d.out_of_range = st_oor_q;
      res_d.moved        = st_moved_q;
      res_d.listed_count = st_cnt_q;
      res_d.last         = 1'b1;
    end else begin
      res_d.kind   = sel_new ? KIND_ENTER : list_kind_q;
      res_d.cell_x = CELL_W'(signed'(COORD_W'(base_x)) + COORD_W'(NB_DX[nb]));
      res_d.cell_y = CELL_W'(signed'(COORD_W'(base_y)) + COORD_W'(NB_DY[nb]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pend_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (out_free) out_v_q <= busy_q;
      if (load) begin
        busy_q <= 1'b1;
        pend_q <= pend_load;
      end else if (step) begin
        if (fin) busy_q <= 1'b0;
        pend_q <= pend_q & (pend_q - PendW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res_d;
    if (load) begin
      list_kind_q <= dec_i.mode ? KIND_LEAVE : KIND_NEIGH;
      oc_x_q      <= dec_i.sector_x;
      oc_y_q      <= dec_i.sector_y;
      nc_x_q      <= ncx;
      nc_y_q      <= ncy;
      st_nsx_q    <= dec_i.mode ? sat_x : '0;
      st_nsy_q    <= dec_i.mode ? sat_y : '0;
      st_oor_q    <= dec_i.mode && oor;
      st_moved_q  <= moved;
      st_cnt_q    <= cnt_load;
    end
  end

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.last == (res_o.kind == KIND_STATUS)))
    else $error("last flag disagrees with status kind");

  a_hold_while_listing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && (pend_q != '0)) |-> !dec_ready_o)
    else $error("new item taken while sectors still pending");

  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.out_of_range) |-> (!res_o.moved && (res_o.listed_count == '0)))
    else $error("out-of-range status carries a move");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.listed_count <= CNT_W'(NB_N)))
    else $error("listed count above nine");

  a_status_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> (res_valid_o && res_o.last && !busy_q) || busy_q)
    else $error("run closed without status beat");

endmodule

// ===== rtl/grid_sector_view_update.sv =====
// Grid area-of-interest unit. A mode 0 item lists the clipped 3x3
// neighbourhood of a sector in row-major order (centre on request); a mode 1
// item divides a world position by the sector pixel size and, if the sector
// changed, lists the sectors leaving the view then those entering it. Every
// run ends with one status beat carrying tlast. The input passes two register
// stages (capture, reciprocal multiply) before the planner. The planner drives
// one result beat per cycle into the output register while it is free: one
// beat per listed sector plus the status beat, from 1 up to 19, taking the
// next item as the status beat goes; items that give only a status beat are
// taken one per cycle while the output is free, which sets the rate.
module grid_sector_view_update import gsv_pkg::*; #(
  parameter int unsigned SectorPixelWidth  = SECTOR_PIXEL_WIDTH,
  parameter int unsigned SectorPixelHeight = SECTOR_PIXEL_HEIGHT,
  parameter int unsigned GridWidth         = GRID_WIDTH,
  parameter int unsigned GridHeight        = GRID_HEIGHT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] sector_x, [11:6] sector_y, [12] include_centre,
  // [27:13] world_x, [42:28] world_y, [47:43] zero
  input  logic [47:0] s_axis_tdata,
  // [0] mode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] cell_x, [11:6] cell_y, [19:12] new_sector_x, [27:20] new_sector_y,
  // [28] out_of_range, [29] moved, [33:30] listed_count, [39:34] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  req_t req;
  dec_t dec;
  res_t res;
  logic dec_valid, dec_ready;

  always_comb begin
    req.mode           = s_axis_tuser;
    req.sector_x       = s_axis_tdata[5:0];
    req.sector_y       = s_axis_tdata[11:6];
    req.include_centre = s_axis_tdata[12];
    req.world_x        = s_axis_tdata[27:13];
    req.world_y        = s_axis_tdata[42:28];
  end

  gsv_front #(
    .SectorPixelWidth (SectorPixelWidth),
    .SectorPixelHeight(SectorPixelHeight)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (req),
    .dec_valid_o(dec_valid),
    .dec_ready_i(dec_ready),
    .dec_o      (dec)
  );

  gsv_emit #(
    .GridWidth (GridWidth),
    .GridHeight(GridHeight)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dec_valid_i(dec_valid),
    .dec_ready_o(dec_ready),
    .dec_i      (dec),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {6'b0, res.listed_count, res.moved, res.out_of_range,
                         res.new_sector_y, res.new_sector_x, res.cell_y, res.cell_x};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
